### src/pmq_pkg.sv
// shared types, codes and the control word broadcast to the cells
`timescale 1ns / 1ps
package pmq_pkg;

	localparam int FUNC_W = 3;
	localparam int PRI_W  = 8;
	localparam int STAT_W = 2;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [FUNC_W-1:0] func_t;
	typedef logic [PRI_W-1:0]  pri_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam func_t FN_ENQ       = 3'd0;
	localparam func_t FN_DEQ_FIRST = 3'd1;
	localparam func_t FN_DEQ_EXACT = 3'd2;
	localparam func_t FN_DEQ_NLOW  = 3'd3;
	localparam func_t FN_CLEAR     = 3'd4;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_BADPRI = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_NONE   = 2'd3;

	localparam logic [ADDR_W-1:0] REG_MAX_PRI = 3'd0;

	typedef struct packed {
		logic enq;        // write the new entry into the cell at the tail
		logic shift_all;  // every cell takes its neighbour's entry, the last cell keeps its own
		logic start;      // arm the search token in all cells
		logic step;       // advance the search by one cell
		logic stop;       // search ends this step (hit or last entry)
		logic hit_any;    // some cell matched this step
		logic exact;      // exact match, else not-lower match
		pri_t req;
		pri_t max_pri;
	} cell_ctl_t;

endpackage

### src/pmq_if.sv
// command and response channel interfaces
`timescale 1ns / 1ps
interface pmq_cmd_if #(
	parameter int PAYLOAD_WIDTH = 32
);
	logic                     valid;
	logic                     ready;
	logic [2:0]               func;
	logic [7:0]               priority_req;
	logic [PAYLOAD_WIDTH-1:0] payload;

	modport source (output valid, func, priority_req, payload, input ready);
	modport sink (input valid, func, priority_req, payload, output ready);
endinterface

interface pmq_rsp_if #(
	parameter int PAYLOAD_WIDTH = 32,
	parameter int CW = 5
);
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic [PAYLOAD_WIDTH-1:0] payload_out;
	logic [7:0]               priority_out;
	logic [CW-1:0]            count_out;

	modport source (output valid, status, payload_out, priority_out, count_out, input ready);
	modport sink (input valid, status, payload_out, priority_out, count_out, output ready);
endinterface

### src/priority_message_queue.sv
// priority message queue top level: row of slot cells, control and result register
//
//  channel | dir | handshake     | carries
//  cmd     | in  | valid/ready   | func, priority_req, payload
//  rsp     | out | valid/ready   | status, payload_out, priority_out, count_out
//  apb     | in  | psel/penable  | priority limit at byte address 0
//
// enqueue, dequeue first, clear and unused codes: the result is registered in the cycle after accept
// dequeue exact / not lower: the search token walks the cell row one slot per cycle, unless a
// waiting result stalls it, up to the first match or, with no match, the last entry
// reset empties the queue at once and sets the priority limit to 255; no clearing pass
// a waiting result stalls the search step and blocks the next word
`timescale 1ns / 1ps
module priority_message_queue #(
	parameter int DEPTH = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pmq_cmd_if.sink                    cmd,
	pmq_rsp_if.source                  rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pmq_pkg::ADDR_W-1:0] paddr,
	input  logic [pmq_pkg::DATA_W-1:0] pwdata,
	output logic [pmq_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int CW = $clog2(DEPTH + 1);

	localparam logic S_IDLE  = 1'b0;
	localparam logic S_SWEEP = 1'b1;

	logic                     state_q, state_d;
	logic [CW-1:0]            count_q, count_d;
	logic                     exact_q;
	pmq_pkg::pri_t            req_q;
	pmq_pkg::pri_t            max_pri;

	logic                     out_valid_q;
	pmq_pkg::status_t         out_status_q;
	logic [PAYLOAD_WIDTH-1:0] out_payload_q;
	pmq_pkg::pri_t            out_priority_q;
	logic [CW-1:0]            out_count_q;

	logic                     can_out;
	logic                     in_fire;
	logic                     res_load;
	pmq_pkg::status_t         res_status;
	logic [PAYLOAD_WIDTH-1:0] res_payload;
	pmq_pkg::pri_t            res_priority;
	pmq_pkg::cell_ctl_t       ctl;

	logic [PAYLOAD_WIDTH-1:0] pay_a  [DEPTH];
	pmq_pkg::pri_t            pri_a  [DEPTH];
	logic [DEPTH-1:0]         pend;
	logic [DEPTH-1:0]         hit;
	logic [DEPTH-1:0]         last;
	logic                     hit_any;
	logic                     last_any;
	logic [PAYLOAD_WIDTH-1:0] hit_payload;
	pmq_pkg::pri_t            hit_priority;

	pmq_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.max_pri (max_pri)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [PAYLOAD_WIDTH-1:0] nx_pay;
		pmq_pkg::pri_t            nx_pri;
		logic                     prv;

		if (i < DEPTH - 1) begin : g_nx
			assign nx_pay = pay_a[i+1];
			assign nx_pri = pri_a[i+1];
		end else begin : g_end
			assign nx_pay = pay_a[i];
			assign nx_pri = pri_a[i];
		end
		if (i > 0) begin : g_pv
			assign prv = pend[i-1];
		end else begin : g_p0
			assign prv = 1'b0;
		end

		pmq_cell #(
			.IDX           (i),
			.PAYLOAD_WIDTH (PAYLOAD_WIDTH),
			.CW            (CW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.count       (count_q),
			.new_payload (cmd.payload),
			.nx_payload  (nx_pay),
			.nx_priority (nx_pri),
			.prev_pend   (prv),
			.payload_q   (pay_a[i]),
			.priority_q  (pri_a[i]),
			.pend_q      (pend[i]),
			.hit         (hit[i]),
			.last        (last[i])
		);
	end

	// at most one cell hits, so an or of the gated entries selects it
	always_comb begin
		hit_payload  = '0;
		hit_priority = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit[i]) begin
				hit_payload  = hit_payload | pay_a[i];
				hit_priority = hit_priority | pri_a[i];
			end
		end
	end

	assign hit_any  = |hit;
	assign last_any = |last;

	assign can_out   = ~out_valid_q | rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) & can_out;
	assign in_fire   = cmd.valid & cmd.ready;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		res_load      = 1'b0;
		res_status    = pmq_pkg::ST_OK;
		res_payload   = '0;
		res_priority  = '0;
		ctl           = '0;
		ctl.max_pri   = max_pri;
		ctl.exact     = exact_q;
		ctl.req       = (state_q == S_IDLE) ? cmd.priority_req : req_q;
		ctl.hit_any   = hit_any;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					res_load = 1'b1;
					unique case (cmd.func)
						pmq_pkg::FN_ENQ: begin
							if (cmd.priority_req > max_pri) begin
								res_status = pmq_pkg::ST_BADPRI;
							end else if (count_q == CW'(DEPTH)) begin
								res_status = pmq_pkg::ST_FULL;
							end else begin
								ctl.enq = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						pmq_pkg::FN_DEQ_FIRST: begin
							if (count_q == '0) begin
								res_status = pmq_pkg::ST_NONE;
							end else begin
								ctl.shift_all = 1'b1;
								res_payload   = pay_a[0];
								res_priority  = pri_a[0];
								count_d       = count_q - 1'b1;
							end
						end
						pmq_pkg::FN_DEQ_EXACT, pmq_pkg::FN_DEQ_NLOW: begin
							if (cmd.priority_req > max_pri) begin
								res_status = pmq_pkg::ST_BADPRI;
							end else if (count_q == '0) begin
								res_status = pmq_pkg::ST_NONE;
							end else begin
								res_load  = 1'b0;
								ctl.start = 1'b1;
								state_d   = S_SWEEP;
							end
						end
						pmq_pkg::FN_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_SWEEP: begin
				if (can_out) begin
					ctl.step = 1'b1;
					ctl.stop = hit_any | last_any;
					if (hit_any) begin
						res_load     = 1'b1;
						res_payload  = hit_payload;
						res_priority = hit_priority;
						count_d      = count_q - 1'b1;
						state_d      = S_IDLE;
					end else if (last_any) begin
						res_load   = 1'b1;
						res_status = pmq_pkg::ST_NONE;
						state_d    = S_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			exact_q <= cmd.func == pmq_pkg::FN_DEQ_EXACT;
			req_q   <= cmd.priority_req;
		end
		if (res_load) begin
			out_status_q   <= res_status;
			out_payload_q  <= res_payload;
			out_priority_q <= res_priority;
			out_count_q    <= count_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.payload_out  = out_payload_q;
	assign rsp.priority_out = out_priority_q;
	assign rsp.count_out    = out_count_q;

endmodule

### src/pmq_cell.sv
// one queue slot: entry storage, match compare and search token
`timescale 1ns / 1ps
module pmq_cell #(
	parameter int IDX = 0,
	parameter int PAYLOAD_WIDTH = 32,
	parameter int CW = 5
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pmq_pkg::cell_ctl_t       ctl,
	input  logic [CW-1:0]            count,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic [PAYLOAD_WIDTH-1:0] nx_payload,
	input  pmq_pkg::pri_t            nx_priority,
	input  logic                     prev_pend,
	output logic [PAYLOAD_WIDTH-1:0] payload_q,
	output pmq_pkg::pri_t            priority_q,
	output logic                     pend_q,
	output logic                     hit,
	output logic                     last
);

	logic occ;
	logic occ_nx;
	logic tok;
	logic match;

	assign occ    = CW'(IDX) < count;
	assign occ_nx = CW'(IDX + 1) < count;
	// token sits on the first cell still pending
	assign tok    = pend_q & ~prev_pend;
	assign match  = ctl.exact ? (priority_q == ctl.req)
	                          : (priority_q <= ctl.max_pri && priority_q <= ctl.req);
	assign hit    = ctl.step & tok & occ & match;
	assign last   = ctl.step & tok & ~occ_nx;

	always_ff @(posedge clk) begin
		if (ctl.enq && count == CW'(IDX)) begin
			payload_q  <= new_payload;
			priority_q <= ctl.req;
		end else if (ctl.shift_all || (ctl.step && ctl.hit_any && pend_q)) begin
			payload_q  <= nx_payload;
			priority_q <= nx_priority;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (ctl.start) begin
			pend_q <= 1'b1;
		end else if (ctl.step) begin
			pend_q <= ctl.stop ? 1'b0 : (pend_q & ~tok);
		end
	end

endmodule

### src/pmq_regs.sv
// apb register block holding the priority limit
`timescale 1ns / 1ps
module pmq_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pmq_pkg::ADDR_W-1:0] paddr,
	input  logic [pmq_pkg::DATA_W-1:0] pwdata,
	output logic [pmq_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output pmq_pkg::pri_t              max_pri
);

	logic sel_max;

	// registers sit on 4-byte steps, low address bits ignored
	assign sel_max = paddr[pmq_pkg::ADDR_W-1:2] == pmq_pkg::REG_MAX_PRI[pmq_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;
	assign prdata  = sel_max ? pmq_pkg::DATA_W'(max_pri) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pri <= '1;
		end else if (psel && penable && pwrite && sel_max) begin
			max_pri <= pwdata[pmq_pkg::PRI_W-1:0];
		end
	end

endmodule

### src/pmq_chk.sv
// port-level checks on the response channel, bound to the top level
`timescale 1ns / 1ps
module pmq_chk #(
	parameter int DEPTH = 16,
	parameter int PAYLOAD_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [1:0]                   status,
	input logic [PAYLOAD_WIDTH-1:0]     payload_out,
	input logic [7:0]                   priority_out,
	input logic [$clog2(DEPTH + 1)-1:0] count_out
);

	localparam int CW = $clog2(DEPTH + 1);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_out) && $stable(status))
		else $error("response word changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count_out <= CW'(DEPTH))
		else $error("count beyond depth");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != pmq_pkg::ST_OK |-> payload_out == '0 && priority_out == '0)
		else $error("entry fields not zero on failure");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == pmq_pkg::ST_FULL |-> count_out == CW'(DEPTH))
		else $error("full reported below depth");

endmodule

bind priority_message_queue pmq_chk #(
	.DEPTH         (DEPTH),
	.PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_pmq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.status),
	.payload_out  (rsp.payload_out),
	.priority_out (rsp.priority_out),
	.count_out    (rsp.count_out)
);

### sim/pmq_checker.sv
// response checker: follows the command, response and register ports and predicts every reply
`timescale 1ns / 1ps
module pmq_checker #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pmq_cmd_if                         cmd,
	pmq_rsp_if                         rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [pmq_pkg::ADDR_W-1:0] paddr,
	input  logic [pmq_pkg::DATA_W-1:0] pwdata,
	input  logic [pmq_pkg::DATA_W-1:0] prdata,
	output int                         errors,
	output int                         pending
);

	typedef struct {
		pmq_pkg::pri_t pri;
		logic [31:0]   payload;
	} msg_t;

	typedef struct {
		pmq_pkg::status_t status;
		logic [31:0]      payload;
		pmq_pkg::pri_t    pri;
		logic [4:0]       count;
	} reply_t;

	msg_t          held[$];
	reply_t        replies_due[$];
	pmq_pkg::pri_t max_pri;
	reply_t        want;

	// one queue operation on the shadow store; returns the reply it must produce
	function automatic reply_t apply_op(pmq_pkg::func_t fn, pmq_pkg::pri_t req,
			logic [31:0] data);
		reply_t r;
		msg_t   m;
		int     hit;
		r.status = pmq_pkg::ST_OK;
		r.payload = '0;
		r.pri = '0;
		hit = -1;
		unique case (fn)
			pmq_pkg::FN_ENQ: begin
				if (req > max_pri) begin
					r.status = pmq_pkg::ST_BADPRI;
				end else if (held.size() >= DEPTH) begin
					r.status = pmq_pkg::ST_FULL;
				end else begin
					m.pri = req;
					m.payload = data;
					held.push_back(m);
				end
			end
			pmq_pkg::FN_DEQ_FIRST: begin
				if (held.size() == 0)
					r.status = pmq_pkg::ST_NONE;
				else
					hit = 0;
			end
			pmq_pkg::FN_DEQ_EXACT, pmq_pkg::FN_DEQ_NLOW: begin
				if (req > max_pri) begin
					r.status = pmq_pkg::ST_BADPRI;
				end else begin
					// oldest match wins; not-lower skips entries above the current limit
					foreach (held[i]) begin
						if (hit < 0 && (fn == pmq_pkg::FN_DEQ_EXACT ? held[i].pri == req :
								(held[i].pri <= max_pri && held[i].pri <= req)))
							hit = i;
					end
					if (hit < 0)
						r.status = pmq_pkg::ST_NONE;
				end
			end
			pmq_pkg::FN_CLEAR: begin
				held.delete();
			end
			default: begin
			end
		endcase
		if (hit >= 0) begin
			r.payload = held[hit].payload;
			r.pri = held[hit].pri;
			held.delete(hit);
		end
		r.count = 5'(held.size());
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held.delete();
			replies_due.delete();
			max_pri = 8'd255;
			errors = 0;
			pending = 0;
		end else begin
			if (psel && penable && pready && paddr == pmq_pkg::REG_MAX_PRI) begin
				if (pwrite) begin
					max_pri = pwdata[7:0];
				end else if (prdata !== {24'd0, max_pri}) begin
					$error("prdata: expected %0d, got %0d", max_pri, prdata);
					errors++;
				end
			end
			if (rsp.valid && rsp.ready) begin
				if (replies_due.size() == 0) begin
					$error("response word with no command waiting");
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp.status);
						errors++;
					end
					if (rsp.payload_out !== want.payload) begin
						$error("payload_out: expected %h, got %h", want.payload, rsp.payload_out);
						errors++;
					end
					if (rsp.priority_out !== want.pri) begin
						$error("priority_out: expected %0d, got %0d", want.pri, rsp.priority_out);
						errors++;
					end
					if (rsp.count_out !== want.count) begin
						$error("count_out: expected %0d, got %0d", want.count, rsp.count_out);
						errors++;
					end
				end
			end
			// a reply never comes out in its own command's cycle, so take replies first
			if (cmd.valid && cmd.ready)
				replies_due.push_back(apply_op(cmd.func, cmd.priority_req, cmd.payload));
			pending = replies_due.size();
		end
	end

endmodule

### sim/testbench.sv
// testbench top: clock, reset, command and register stimulus, response pacing and verdict
`timescale 1ns / 1ps
module testbench;

	localparam int DEPTH = 16;
	localparam int N_PHASES = 11;
	localparam int PHASE_LEN = 150;

	// codes with no operation behind them
	localparam pmq_pkg::func_t FN_SPARE_5 = 3'd5;
	localparam pmq_pkg::func_t FN_SPARE_6 = 3'd6;
	localparam pmq_pkg::func_t FN_SPARE_7 = 3'd7;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [pmq_pkg::ADDR_W-1:0] paddr;
	logic [pmq_pkg::DATA_W-1:0] pwdata;
	logic [pmq_pkg::DATA_W-1:0] prdata;
	logic                       pready;
	int                         errors;
	int                         pending;
	bit                         gaps_on;
	bit                         stalls_on;
	pmq_pkg::pri_t              palette [8];
	int                         max_plan [N_PHASES] =
		'{255, 0, 255, 100, 1, 254, 0, 128, 17, 200, 255};

	pmq_cmd_if #(.PAYLOAD_WIDTH(32)) cmd_ch ();
	pmq_rsp_if #(.PAYLOAD_WIDTH(32), .CW(5)) rsp_ch ();

	priority_message_queue #(.DEPTH(DEPTH), .PAYLOAD_WIDTH(32)) DUT (
		.clk, .arst_n, .cmd(cmd_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	pmq_checker #(.DEPTH(DEPTH)) queue_chk (
		.clk, .arst_n, .cmd(cmd_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata, .prdata,
		.errors, .pending
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic send_word(pmq_pkg::func_t fn, pmq_pkg::pri_t pr, logic [31:0] data);
		int gap;
		gap = gaps_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.func <= fn;
		cmd_ch.priority_req <= pr;
		cmd_ch.payload <= data;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
	endtask

	// hold off commands until every reply is back
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic reg_access(bit wr, logic [pmq_pkg::DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= pmq_pkg::REG_MAX_PRI;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_max(pmq_pkg::pri_t v);
		drain();
		reg_access(1'b1, {24'd0, v});
		reg_access(1'b0, '0);
	endtask

	// mode 0 balanced, 1 tends to fill the store, 2 tends to empty it
	function automatic pmq_pkg::func_t pick_func(int mode);
		int r;
		int enq_pct;
		enq_pct = (mode == 1) ? 65 : (mode == 2) ? 20 : 40;
		r = $urandom_range(0, 99);
		if (r < enq_pct)
			return pmq_pkg::FN_ENQ;
		r = $urandom_range(0, 99);
		if (r < 25)
			return pmq_pkg::FN_DEQ_FIRST;
		if (r < 55)
			return pmq_pkg::FN_DEQ_EXACT;
		if (r < 85)
			return pmq_pkg::FN_DEQ_NLOW;
		if (r < 93)
			return pmq_pkg::FN_CLEAR;
		return (r < 96) ? FN_SPARE_5 : (r < 98) ? FN_SPARE_6 : FN_SPARE_7;
	endfunction

	// mostly a small set of priorities so that exact searches hit
	function automatic pmq_pkg::pri_t pick_pri(pmq_pkg::pri_t cap);
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return palette[$urandom_range(0, 7)];
		if (r < 90)
			return pmq_pkg::pri_t'($urandom_range(0, cap));
		return pmq_pkg::pri_t'($urandom_range(0, 255));
	endfunction

	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = stalls_on ? $urandom_range(0, 14) : 0;
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
		end
	end

	initial begin
		int            mode;
		pmq_pkg::pri_t cur_max;
		cmd_ch.valid = 1'b0;
		cmd_ch.func = pmq_pkg::FN_ENQ;
		cmd_ch.priority_req = '0;
		cmd_ch.payload = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = pmq_pkg::REG_MAX_PRI;
		pwdata = '0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_access(1'b0, '0);

		// empty store, extremes of priority and payload, every operation
		send_word(pmq_pkg::FN_DEQ_FIRST, 8'd0, 32'd0);
		send_word(pmq_pkg::FN_DEQ_EXACT, 8'd5, 32'd0);
		send_word(pmq_pkg::FN_DEQ_NLOW, 8'd255, 32'd0);
		send_word(pmq_pkg::FN_ENQ, 8'd255, 32'hFFFF_FFFF);
		send_word(pmq_pkg::FN_ENQ, 8'd0, 32'h0000_0000);
		send_word(pmq_pkg::FN_ENQ, 8'd7, 32'hA5A5_5A5A);
		send_word(pmq_pkg::FN_ENQ, 8'd7, 32'h1234_5678);
		send_word(pmq_pkg::FN_DEQ_EXACT, 8'd7, 32'hFFFF_FFFF);
		send_word(pmq_pkg::FN_DEQ_EXACT, 8'd9, 32'd0);
		send_word(pmq_pkg::FN_DEQ_NLOW, 8'd6, 32'd0);
		send_word(FN_SPARE_5, 8'd3, 32'hDEAD_BEEF);
		send_word(FN_SPARE_6, 8'd255, 32'd1);
		send_word(FN_SPARE_7, 8'd0, 32'd2);
		send_word(pmq_pkg::FN_DEQ_FIRST, 8'd200, 32'd0);
		send_word(pmq_pkg::FN_CLEAR, 8'd0, 32'd0);
		send_word(pmq_pkg::FN_DEQ_FIRST, 8'd0, 32'd0);

		// priority limit checks
		set_max(8'd100);
		send_word(pmq_pkg::FN_ENQ, 8'd100, 32'h0BAD_F00D);
		send_word(pmq_pkg::FN_ENQ, 8'd101, 32'h1111_2222);
		send_word(pmq_pkg::FN_DEQ_EXACT, 8'd200, 32'd0);
		send_word(pmq_pkg::FN_DEQ_NLOW, 8'd101, 32'd0);
		send_word(pmq_pkg::FN_DEQ_FIRST, 8'd255, 32'd0);

		// an entry left above a lowered limit is passed over by not-lower
		set_max(8'd255);
		send_word(pmq_pkg::FN_ENQ, 8'd200, 32'h7777_0001);
		send_word(pmq_pkg::FN_ENQ, 8'd30, 32'h7777_0002);
		set_max(8'd100);
		send_word(pmq_pkg::FN_DEQ_NLOW, 8'd100, 32'd0);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			cur_max = pmq_pkg::pri_t'(max_plan[ph]);
			if (ph == 6)
				cur_max = pmq_pkg::pri_t'($urandom_range(0, 255));
			set_max(cur_max);
			palette[0] = 8'd0;
			palette[1] = cur_max;
			for (int k = 2; k < 8; k++)
				palette[k] = pmq_pkg::pri_t'($urandom_range(0, cur_max));
			mode = $urandom_range(0, 2);
			gaps_on = !(ph == 2 || $urandom_range(0, 3) == 0);
			stalls_on = !(ph == 2 || $urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (n == PHASE_LEN / 2 && (ph == 0 || $urandom_range(0, 1) == 1))
					drain();
				send_word(pick_func(mode), pick_pri(cur_max), $urandom());
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
src/pmq_pkg.sv
src/pmq_if.sv
src/pmq_cell.sv
src/pmq_regs.sv
src/priority_message_queue.sv
src/pmq_chk.sv
sim/pmq_checker.sv
sim/testbench.sv
